// ===== hdl/multi_mode_object_pool_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-mode object pool
// Shared immediate-implication and next-cycle-implication property forms.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_OBJECT_POOL_ASSERT_SVH
`define MULTI_MODE_OBJECT_POOL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMOP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("object pool assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MMOP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("object pool assertion failed");

`endif

// ===== hdl/mmop_pkg.sv =====
// ----------------------------------------------------------------------------
// mmop_pkg
// Shared codes, configuration record and state types of the object pool.
// ----------------------------------------------------------------------------
package mmop_pkg;

   localparam int NUM_POOLS_DEFAULT      = 4;
   localparam int SLOTS_PER_POOL_DEFAULT = 64;
   localparam int OBJECT_WIDTH_DEFAULT   = 64;

   // Request kinds.
   localparam logic [1:0] FUNC_PUT   = 2'd0;
   localparam logic [1:0] FUNC_GET   = 2'd1;
   localparam logic [1:0] FUNC_FLUSH = 2'd2;

   // Pool modes.
   localparam logic [1:0] MODE_MANUAL = 2'd0;
   localparam logic [1:0] MODE_STACK  = 2'd1;
   localparam logic [1:0] MODE_QUEUE  = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_POOL  = 3'd1;
   localparam logic [2:0] STATUS_BAD_INDEX = 3'd2;
   localparam logic [2:0] STATUS_FULL      = 3'd3;
   localparam logic [2:0] STATUS_EMPTY     = 3'd4;
   localparam logic [2:0] STATUS_BAD_MODE  = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_POOLS_CREATED = 3'd0;
   localparam logic [2:0] CSR_POOL_MODES    = 3'd1;
   localparam logic [2:0] CSR_CAPACITY0     = 3'd2;
   localparam logic [2:0] CSR_CAPACITY1     = 3'd3;
   localparam logic [2:0] CSR_CAPACITY2     = 3'd4;
   localparam logic [2:0] CSR_CAPACITY3     = 3'd5;

   typedef struct packed {
      logic [2:0]      pools_created;
      logic [7:0]      pool_modes;
      logic [3:0][6:0] capacity;
   } mmop_cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_FLUSH,
      ST_COMPACT,
      ST_APPEND
   } mmop_state_type;

   typedef enum logic [2:0] {
      ACT_RESPOND,
      ACT_WRITE,
      ACT_READ,
      ACT_FLUSH,
      ACT_COMPACT
   } mmop_act_type;

endpackage

// ===== hdl/mmop_slot_ram.sv =====
// ----------------------------------------------------------------------------
// mmop_slot_ram
// Slot storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mmop_slot_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 64,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mmop_csr.sv =====
// ----------------------------------------------------------------------------
// mmop_csr
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module mmop_csr
   import mmop_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_write_data,
   output mmop_cfg_type cfg
);

   mmop_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POOLS_CREATED: cfg_in.pools_created = csr_write_data[2:0];
            CSR_POOL_MODES:    cfg_in.pool_modes    = csr_write_data;
            CSR_CAPACITY0:     cfg_in.capacity[0]   = csr_write_data[6:0];
            CSR_CAPACITY1:     cfg_in.capacity[1]   = csr_write_data[6:0];
            CSR_CAPACITY2:     cfg_in.capacity[2]   = csr_write_data[6:0];
            CSR_CAPACITY3:     cfg_in.capacity[3]   = csr_write_data[6:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pools_created <= 3'd1;
         cfg_ff.pool_modes    <= 8'd0;
         cfg_ff.capacity[0]   <= 7'd64;
         cfg_ff.capacity[1]   <= 7'd0;
         cfg_ff.capacity[2]   <= 7'd0;
         cfg_ff.capacity[3]   <= 7'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/mmop_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmop_ctrl
// Request sequencer: pointer registers, request decode and the memory walks
// for clearing, flushing and queue compaction.
// ----------------------------------------------------------------------------
module mmop_ctrl
   import mmop_pkg::*;
#(
   parameter int NUM_POOLS      = NUM_POOLS_DEFAULT,
   parameter int SLOTS_PER_POOL = SLOTS_PER_POOL_DEFAULT,
   parameter int OBJECT_WIDTH   = OBJECT_WIDTH_DEFAULT,
   parameter int AW             = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mmop_cfg_type            cfg,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_func,
   input  logic [1:0]              req_pool_id,
   input  logic [5:0]              req_slot_index,
   input  logic [OBJECT_WIDTH-1:0] req_object_data,
   output logic                    rsp_strobe,
   output logic                    rsp_ok,
   output logic [2:0]              rsp_status,
   output logic [OBJECT_WIDTH-1:0] rsp_read_data,
   output logic                    mem_wr_en,
   output logic [AW-1:0]           mem_wr_addr,
   output logic [OBJECT_WIDTH-1:0] mem_wr_data,
   output logic                    mem_rd_en,
   output logic [AW-1:0]           mem_rd_addr,
   input  logic [OBJECT_WIDTH-1:0] mem_rd_data
);

   localparam int DEPTH  = NUM_POOLS * SLOTS_PER_POOL;
   localparam int PTR_W  = $clog2(SLOTS_PER_POOL + 1);
   localparam int POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
   localparam int CW     = (PTR_W > 7) ? PTR_W : 7;

   function automatic logic [AW-1:0] slot_addr(input logic [POOL_W-1:0] pool,
                                               input logic [PTR_W:0]    slot);
      logic [AW-1:0] base;
      base = AW'(int'(pool) * SLOTS_PER_POOL);
      return base + AW'(slot);
   endfunction

   mmop_state_type state_ff, state_in;

   logic [PTR_W-1:0] top_ff [NUM_POOLS];
   logic [PTR_W-1:0] bot_ff [NUM_POOLS];
   logic [PTR_W-1:0] top_new, bot_new;
   logic             top_we, bot_we;

   logic [AW-1:0]    clear_ff, clear_in;
   logic [PTR_W-1:0] cnt_ff, cnt_in;

   logic [1:0]              func_ff;
   logic [1:0]              pool_id_ff;
   logic [5:0]              slot_ff;
   logic [OBJECT_WIDTH-1:0] obj_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [2:0]              rsp_status_ff, rsp_status_in;
   logic [OBJECT_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic [POOL_W+1:0] pool_ext;
   logic [POOL_W-1:0] pool_sel;
   logic              pool_ok;
   logic [1:0]        mode;
   logic [CW-1:0]     cap_raw;
   logic [PTR_W-1:0]  cap, top_cur, bot_cur, live;
   logic              accept;

   mmop_act_type     act;
   logic [2:0]       dec_status;
   logic [PTR_W-1:0] dec_slot;

   assign accept   = start && (state_ff == ST_IDLE);
   assign pool_ext = {{POOL_W{1'b0}}, pool_id_ff};
   assign pool_sel = pool_ext[POOL_W-1:0];
   assign pool_ok  = ({1'b0, pool_id_ff} < cfg.pools_created) &&
                     (int'(pool_id_ff) < NUM_POOLS);
   assign mode     = cfg.pool_modes[2*pool_id_ff +: 2];
   assign cap_raw  = CW'(cfg.capacity[pool_id_ff]);
   assign cap      = (cap_raw > CW'(SLOTS_PER_POOL)) ? PTR_W'(SLOTS_PER_POOL)
                                                     : PTR_W'(cap_raw);
   assign top_cur  = top_ff[pool_sel];
   assign bot_cur  = bot_ff[pool_sel];
   assign live     = top_cur - bot_cur;

   // Request decode, evaluated while the request sits in the execute state.
   always_comb begin
      act        = ACT_RESPOND;
      dec_status = STATUS_OK;
      dec_slot   = PTR_W'(slot_ff);
      top_we     = 1'b0;
      bot_we     = 1'b0;
      top_new    = top_cur;
      bot_new    = bot_cur;
      if (func_ff != FUNC_PUT && func_ff != FUNC_GET && func_ff != FUNC_FLUSH) begin
         dec_status = STATUS_BAD_MODE;
      end else if (!pool_ok) begin
         dec_status = STATUS_BAD_POOL;
      end else if (func_ff == FUNC_FLUSH) begin
         top_we  = 1'b1;
         bot_we  = 1'b1;
         top_new = '0;
         bot_new = '0;
         if (cap != '0) begin
            act = ACT_FLUSH;
         end
      end else begin
         unique case (mode)
            MODE_MANUAL: begin
               if (CW'(slot_ff) >= CW'(cap)) begin
                  dec_status = STATUS_BAD_INDEX;
               end else begin
                  act = (func_ff == FUNC_PUT) ? ACT_WRITE : ACT_READ;
               end
            end
            MODE_STACK: begin
               if (func_ff == FUNC_PUT) begin
                  if (top_cur >= cap) begin
                     dec_status = STATUS_FULL;
                  end else begin
                     act      = ACT_WRITE;
                     dec_slot = top_cur;
                     top_we   = 1'b1;
                     top_new  = top_cur + 1'b1;
                  end
               end else if (top_cur == '0) begin
                  dec_status = STATUS_EMPTY;
               end else begin
                  act      = ACT_READ;
                  dec_slot = top_cur - 1'b1;
                  top_we   = 1'b1;
                  top_new  = top_cur - 1'b1;
               end
            end
            MODE_QUEUE: begin
               if (func_ff == FUNC_PUT) begin
                  if (top_cur < cap) begin
                     act      = ACT_WRITE;
                     dec_slot = top_cur;
                     top_we   = 1'b1;
                     top_new  = top_cur + 1'b1;
                  end else if (bot_cur == '0 || bot_cur > top_cur || live >= cap) begin
                     dec_status = STATUS_FULL;
                  end else begin
                     act = ACT_COMPACT;
                  end
               end else if (bot_cur >= top_cur) begin
                  dec_status = STATUS_EMPTY;
               end else begin
                  act      = ACT_READ;
                  dec_slot = bot_cur;
                  bot_we   = 1'b1;
                  bot_new  = bot_cur + 1'b1;
               end
            end
            default: dec_status = STATUS_BAD_MODE;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (clear_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:    if (start) state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (act)
               ACT_READ:    state_in = ST_READ;
               ACT_FLUSH:   state_in = ST_FLUSH;
               ACT_COMPACT: state_in = ST_COMPACT;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_READ:    state_in = ST_IDLE;
         ST_FLUSH:   if (cnt_ff == cap - 1'b1) state_in = ST_IDLE;
         ST_COMPACT: if (cnt_ff == live) state_in = ST_APPEND;
         ST_APPEND:  state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   // Memory ports, counters and the response.
   always_comb begin
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      clear_in      = clear_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_ok_in     = rsp_ok_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clear_ff;
            clear_in    = clear_ff + 1'b1;
         end
         ST_EXEC: begin
            cnt_in = '0;
            unique case (act)
               ACT_WRITE: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = slot_addr(pool_sel, {1'b0, dec_slot});
                  mem_wr_data = obj_ff;
               end
               ACT_READ: begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = slot_addr(pool_sel, {1'b0, dec_slot});
               end
               default: begin
               end
            endcase
            if (act == ACT_RESPOND || act == ACT_WRITE) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = (dec_status == STATUS_OK);
               rsp_status_in = dec_status;
               rsp_data_in   = '0;
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_ok_in     = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_data_in   = mem_rd_data;
         end
         ST_FLUSH: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_addr(pool_sel, {1'b0, cnt_ff});
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == cap - 1'b1) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_data_in   = '0;
            end
         end
         ST_COMPACT: begin
            // Read slot bottom+k while writing the word read last cycle to k-1.
            mem_rd_en   = (cnt_ff < live);
            mem_rd_addr = slot_addr(pool_sel, {1'b0, bot_cur} + {1'b0, cnt_ff});
            mem_wr_en   = (cnt_ff != '0);
            mem_wr_addr = slot_addr(pool_sel, {1'b0, cnt_ff - 1'b1});
            mem_wr_data = mem_rd_data;
            cnt_in      = cnt_ff + 1'b1;
         end
         ST_APPEND: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = slot_addr(pool_sel, {1'b0, live});
            mem_wr_data   = obj_ff;
            rsp_valid_in  = 1'b1;
            rsp_ok_in     = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_data_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NUM_POOLS; p++) begin
            top_ff[p] <= '0;
            bot_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_EXEC) begin
            if (top_we) top_ff[pool_sel] <= top_new;
            if (bot_we) bot_ff[pool_sel] <= bot_new;
         end
         if (state_ff == ST_APPEND) begin
            top_ff[pool_sel] <= live + 1'b1;
            bot_ff[pool_sel] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_func;
         pool_id_ff <= req_pool_id;
         slot_ff    <= req_slot_index;
         obj_ff     <= req_object_data;
      end
      rsp_ok_ff     <= rsp_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// ===== hdl/multi_mode_object_pool.sv =====
// ----------------------------------------------------------------------------
// multi_mode_object_pool
// Pools of object slots run as manual, stack or queue stores.
// ----------------------------------------------------------------------------
// Requests come in as command beats: a beat is taken at a rising edge where
// start is high and busy is low. It names a put, get or flush, a pool, a
// slot (manual pools only) and the object word to store.
// Every request produces exactly one result beat: rsp_strobe is high for one
// cycle with ok, status and, for a successful get, the stored word. The
// receiver cannot hold results off, so they are never stalled.
// Steps from the accepting edge to the strobe; busy holds off new beats:
//   rejected requests and puts that need no compaction: the execute state;
//   gets: the execute state, then the read state for the slot memory read;
//   flush: the execute state, then the flush walk, one slot zeroed per cycle;
//   queue put with compaction: the execute, compaction and append states, one
//   entry moved per cycle through the single read port and single write port.
// After reset the slot memory is swept to zero, one entry per cycle, through
// all NUM_POOLS * SLOTS_PER_POOL entries; busy stays high during the sweep.
// Configuration writes are taken at any time on csr_write_enable, but are
// meant to be issued only while the pool is idle.
// ----------------------------------------------------------------------------
module multi_mode_object_pool
   import mmop_pkg::*;
#(
   parameter int NUM_POOLS      = NUM_POOLS_DEFAULT,
   parameter int SLOTS_PER_POOL = SLOTS_PER_POOL_DEFAULT,
   parameter int OBJECT_WIDTH   = OBJECT_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_func,
   input  logic [1:0]              req_pool_id,
   input  logic [5:0]              req_slot_index,
   input  logic [OBJECT_WIDTH-1:0] req_object_data,
   output logic                    rsp_strobe,
   output logic                    rsp_ok,
   output logic [2:0]              rsp_status,
   output logic [OBJECT_WIDTH-1:0] rsp_read_data,
   input  logic                    csr_write_enable,
   input  logic [2:0]              csr_index,
   input  logic [7:0]              csr_write_data
);

   // All pools share one memory; pool p owns a contiguous block of slots.
   localparam int DEPTH = NUM_POOLS * SLOTS_PER_POOL;
   localparam int AW    = $clog2(DEPTH);

   mmop_cfg_type            cfg;
   logic                    mem_wr_en, mem_rd_en;
   logic [AW-1:0]           mem_wr_addr, mem_rd_addr;
   logic [OBJECT_WIDTH-1:0] mem_wr_data, mem_rd_data;

   mmop_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // The sequencer owns the per-pool pointers and every memory access.
   mmop_ctrl #(
      .NUM_POOLS      (NUM_POOLS),
      .SLOTS_PER_POOL (SLOTS_PER_POOL),
      .OBJECT_WIDTH   (OBJECT_WIDTH),
      .AW             (AW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_pool_id     (req_pool_id),
      .req_slot_index  (req_slot_index),
      .req_object_data (req_object_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_status      (rsp_status),
      .rsp_read_data   (rsp_read_data),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   mmop_slot_ram #(
      .DEPTH (DEPTH),
      .WIDTH (OBJECT_WIDTH),
      .AW    (AW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== hdl/mmop_checker.sv =====
// ----------------------------------------------------------------------------
// mmop_checker
// Port-level checks of the object pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_mode_object_pool_assert.svh"

module mmop_checker
   import mmop_pkg::*;
#(
   parameter int OBJECT_WIDTH = OBJECT_WIDTH_DEFAULT
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_strobe,
   input logic                    rsp_ok,
   input logic [2:0]              rsp_status,
   input logic [OBJECT_WIDTH-1:0] rsp_read_data
);

   // A taken beat makes the block busy and no result shows in the next cycle.
   `MMOP_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_strobe)

   // A result is shown only once the block has gone back to idle.
   `MMOP_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy)

   // The ok flag agrees with the status code.
   `MMOP_ASSERT_IMP(a_ok_status, clock, reset, rsp_strobe, rsp_ok == (rsp_status == STATUS_OK))

   // Failed requests return a zero word.
   `MMOP_ASSERT_IMP(a_fail_zero, clock, reset, rsp_strobe && !rsp_ok, rsp_read_data == '0)

endmodule

bind multi_mode_object_pool mmop_checker #(.OBJECT_WIDTH(OBJECT_WIDTH)) u_mmop_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_ok        (rsp_ok),
   .rsp_status    (rsp_status),
   .rsp_read_data (rsp_read_data)
);

// ===== tb/sv/multi_mode_object_pool_test.sv =====
// ----------------------------------------------------------------------------
// multi_mode_object_pool_test
// Self-checking testbench for the multi-mode object pool. A clocked driver
// sends request beats from a pending queue. A shadow model of the pools
// predicts each result when its beat is accepted. A clocked monitor checks
// every result beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module multi_mode_object_pool_test;
   import mmop_pkg::*;

   localparam int POOL_COUNT = NUM_POOLS_DEFAULT;
   localparam int POOL_SLOTS = SLOTS_PER_POOL_DEFAULT;
   localparam int OBJ_BITS   = OBJECT_WIDTH_DEFAULT;

   // The package names only the legal codes. These are the codes the block must
   // reject.
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
   localparam logic [1:0] MODE_INVALID = 2'd3;

   typedef struct packed {
      logic [1:0]          func;
      logic [1:0]          pool_id;
      logic [5:0]          slot_index;
      logic [OBJ_BITS-1:0] object_data;
   } pool_request_type;

   typedef struct packed {
      logic                ok;
      logic [2:0]          status;
      logic [OBJ_BITS-1:0] read_data;
   } pool_response_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [1:0]          req_func         = '0;
   logic [1:0]          req_pool_id      = '0;
   logic [5:0]          req_slot_index   = '0;
   logic [OBJ_BITS-1:0] req_object_data  = '0;
   logic                rsp_strobe;
   logic                rsp_ok;
   logic [2:0]          rsp_status;
   logic [OBJ_BITS-1:0] rsp_read_data;
   logic                csr_write_enable = 1'b0;
   logic [2:0]          csr_index        = '0;
   logic [7:0]          csr_write_data   = '0;

   multi_mode_object_pool #(
      .NUM_POOLS      (POOL_COUNT),
      .SLOTS_PER_POOL (POOL_SLOTS),
      .OBJECT_WIDTH   (OBJ_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_pool_id      (req_pool_id),
      .req_slot_index   (req_slot_index),
      .req_object_data  (req_object_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_ok           (rsp_ok),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // Shadow copy of the pool storage, the pointers and the register file.
   // The block clears its storage at reset, so every slot starts at zero here.
   logic [OBJ_BITS-1:0] slot_words [POOL_COUNT*POOL_SLOTS];
   int                  shadow_top    [POOL_COUNT];
   int                  shadow_bottom [POOL_COUNT];
   logic [2:0]          pools_created_q = 3'd1;
   logic [7:0]          pool_modes_q    = 8'd0;
   logic [6:0]          capacity_q [4]  = '{7'd64, 7'd0, 7'd0, 7'd0};

   pool_request_type  pending_requests [$];
   pool_response_type expected_responses [$];
   pool_request_type  beat_on_port;
   pool_response_type seen_response;
   pool_response_type oldest_expected;
   int                beats_outstanding = 0;
   int                sender_idle_pct   = 0;
   bit                failed            = 1'b0;

   initial begin
      foreach (slot_words[i]) slot_words[i] = '0;
      foreach (shadow_top[i]) begin
         shadow_top[i]    = 0;
         shadow_bottom[i] = 0;
      end
   end

   // A capacity register above the pool size acts as the full pool.
   function automatic int usable_slots(input logic [1:0] pool);
      return (capacity_q[pool] > POOL_SLOTS) ? POOL_SLOTS : int'(capacity_q[pool]);
   endfunction

   function automatic int live_pool_limit();
      return (pools_created_q > POOL_COUNT) ? POOL_COUNT : int'(pools_created_q);
   endfunction

   // Applies one request to the shadow pools and returns the result the block
   // owes for it. The checks run in the block's order: request kind, pool id,
   // manual slot index, then mode.
   function automatic pool_response_type serve_request(input pool_request_type rq);
      pool_response_type   rsp;
      logic [2:0]          st;
      logic [OBJ_BITS-1:0] word;
      logic [1:0]          mode;
      int                  cap;
      int                  base;
      int                  t;
      int                  b;
      st   = STATUS_OK;
      word = '0;
      if (rq.func == FUNC_UNKNOWN) begin
         st = STATUS_BAD_MODE;
      end else if (rq.pool_id >= live_pool_limit()) begin
         st = STATUS_BAD_POOL;
      end else begin
         cap  = usable_slots(rq.pool_id);
         mode = pool_modes_q[2*rq.pool_id +: 2];
         base = rq.pool_id * POOL_SLOTS;
         t    = shadow_top[rq.pool_id];
         b    = shadow_bottom[rq.pool_id];
         if (rq.func == FUNC_FLUSH) begin
            // A flush ignores the mode and clears every slot up to the capacity.
            for (int i = 0; i < cap; i++) slot_words[base + i] = '0;
            shadow_top[rq.pool_id]    = 0;
            shadow_bottom[rq.pool_id] = 0;
         end else if (mode == MODE_MANUAL) begin
            if (rq.slot_index >= cap) begin
               st = STATUS_BAD_INDEX;
            end else if (rq.func == FUNC_PUT) begin
               slot_words[base + rq.slot_index] = rq.object_data;
            end else begin
               word = slot_words[base + rq.slot_index];
            end
         end else if (mode == MODE_STACK) begin
            if (rq.func == FUNC_PUT) begin
               if (t >= cap) begin
                  st = STATUS_FULL;
               end else begin
                  slot_words[base + t]   = rq.object_data;
                  shadow_top[rq.pool_id] = t + 1;
               end
            end else if (t == 0) begin
               st = STATUS_EMPTY;
            end else begin
               shadow_top[rq.pool_id] = t - 1;
               word = slot_words[base + t - 1];
            end
         end else if (mode == MODE_QUEUE) begin
            if (rq.func == FUNC_PUT) begin
               if (t >= cap) begin
                  // Full at the top: slide the live entries down to slot 0 if
                  // that frees at least one slot, otherwise refuse the put.
                  if (b == 0 || b > t || t - b >= cap) begin
                     st = STATUS_FULL;
                  end else begin
                     for (int i = 0; i < t - b; i++) begin
                        slot_words[base + i] = slot_words[base + b + i];
                     end
                     t = t - b;
                     shadow_bottom[rq.pool_id] = 0;
                  end
               end
               if (st == STATUS_OK) begin
                  slot_words[base + t]   = rq.object_data;
                  shadow_top[rq.pool_id] = t + 1;
               end
            end else if (b >= t) begin
               st = STATUS_EMPTY;
            end else begin
               shadow_bottom[rq.pool_id] = b + 1;
               word = slot_words[base + b];
            end
         end else begin
            st = STATUS_BAD_MODE;
         end
      end
      rsp.ok        = (st == STATUS_OK);
      rsp.status    = st;
      rsp.read_data = (st == STATUS_OK) ? word : '0;
      return rsp;
   endfunction

   // Driver. A beat is taken at an edge where start is high and busy is low,
   // and it is predicted at that same edge. A beat held against busy stays on
   // the port untouched. Otherwise the next pending beat goes out unless the
   // sender chooses to idle for this cycle.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_responses.push_back(serve_request(beat_on_port));
         end
         if (!start || !busy) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
               beat_on_port    = pending_requests.pop_front();
               start           <= 1'b1;
               req_func        <= beat_on_port.func;
               req_pool_id     <= beat_on_port.pool_id;
               req_slot_index  <= beat_on_port.slot_index;
               req_object_data <= beat_on_port.object_data;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every result beat lasts exactly one cycle and cannot be held off,
   // so it is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen_response = '{rsp_ok, rsp_status, rsp_read_data};
         if (expected_responses.size() == 0) begin
            $display("%0t: result beat with nothing expected: ok %0b status %0d data %h",
                     $time, rsp_ok, rsp_status, rsp_read_data);
            failed = 1'b1;
         end else begin
            oldest_expected = expected_responses.pop_front();
            beats_outstanding--;
            if (seen_response.ok !== oldest_expected.ok) begin
               $display("%0t: ok mismatch: expected %0b actual %0b",
                        $time, oldest_expected.ok, seen_response.ok);
               failed = 1'b1;
            end
            if (seen_response.status !== oldest_expected.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, oldest_expected.status, seen_response.status);
               failed = 1'b1;
            end
            if (seen_response.read_data !== oldest_expected.read_data) begin
               $display("%0t: read_data mismatch: expected %h actual %h",
                        $time, oldest_expected.read_data, seen_response.read_data);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic queue_request(input logic [1:0] func, input logic [1:0] pool,
                                input logic [5:0] slot, input logic [OBJ_BITS-1:0] data);
      pending_requests.push_back('{func, pool, slot, data});
      beats_outstanding++;
   endtask

   // Waits until every queued beat has produced its result and the block has
   // dropped busy. This also covers the storage sweep that follows reset.
   task automatic wait_until_idle();
      do @(posedge clock); while (beats_outstanding != 0 || busy !== 1'b0);
   endtask

   // One register write. The shadow copy changes along with the block's copy.
   // Writes only happen while the block is idle.
   task automatic write_register(input logic [2:0] index, input logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_POOLS_CREATED: pools_created_q = value[2:0];
         CSR_POOL_MODES:    pool_modes_q    = value;
         CSR_CAPACITY0:     capacity_q[0]   = value[6:0];
         CSR_CAPACITY1:     capacity_q[1]   = value[6:0];
         CSR_CAPACITY2:     capacity_q[2]   = value[6:0];
         CSR_CAPACITY3:     capacity_q[3]   = value[6:0];
         default: ;
      endcase
   endtask

   task automatic write_all_registers(input logic [2:0] pools, input logic [7:0] modes,
                                      input logic [6:0] cap0, input logic [6:0] cap1,
                                      input logic [6:0] cap2, input logic [6:0] cap3);
      write_register(CSR_POOLS_CREATED, {5'd0, pools});
      write_register(CSR_POOL_MODES, modes);
      write_register(CSR_CAPACITY0, {1'b0, cap0});
      write_register(CSR_CAPACITY1, {1'b0, cap1});
      write_register(CSR_CAPACITY2, {1'b0, cap2});
      write_register(CSR_CAPACITY3, {1'b0, cap3});
   endtask

   // Small capacities dominate so that stacks and queues run full, empty and
   // compact often. The extremes and the oversized values still show up.
   function automatic logic [6:0] pick_capacity();
      case ($urandom_range(9))
         0:       return 7'd0;
         1:       return 7'd64;
         2:       return 7'($urandom_range(127, 65));
         3:       return 7'd1;
         default: return 7'($urandom_range(8, 2));
      endcase
   endfunction

   task automatic configure_random_phase(input int phase);
      logic [2:0] pools;
      logic [7:0] modes;
      case (phase % 6)
         0, 3:    pools = 3'd4;
         1:       pools = 3'd7;
         2:       pools = 3'($urandom_range(7));
         4:       pools = 3'd2;
         default: pools = 3'd3;
      endcase
      if (phase == 7) pools = 3'd0;
      case (phase)
         0:       modes = {4{MODE_QUEUE}};
         1:       modes = {4{MODE_STACK}};
         2:       modes = {4{MODE_MANUAL}};
         default: modes = 8'($urandom_range(255));
      endcase
      write_all_registers(pools, modes, pick_capacity(), pick_capacity(),
                          pick_capacity(), pick_capacity());
   endtask

   // Random beats run in bursts that lean alternately toward gets and puts, so
   // the pools fill up and drain again. A few beats name missing pools, out of
   // range slots or the unknown request kind.
   task automatic plan_random_phase(input int count);
      int                  limit;
      int                  cap;
      int                  put_bias;
      int                  burst_left;
      int                  roll;
      logic [1:0]          func;
      logic [1:0]          pool;
      logic [5:0]          slot;
      logic [OBJ_BITS-1:0] data;
      limit      = live_pool_limit();
      put_bias   = 50;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(24, 4);
            put_bias   = (put_bias >= 50) ? 25 : 75;
         end
         burst_left--;
         if (limit != 0 && $urandom_range(19) != 0) begin
            pool = 2'($urandom_range(limit - 1));
         end else begin
            pool = 2'($urandom_range(3));
         end
         roll = $urandom_range(99);
         if (roll < 2) begin
            func = FUNC_UNKNOWN;
         end else if (roll < 6) begin
            func = FUNC_FLUSH;
         end else if ($urandom_range(99) < put_bias) begin
            func = FUNC_PUT;
         end else begin
            func = FUNC_GET;
         end
         cap = usable_slots(pool);
         if (cap != 0 && $urandom_range(9) != 0) begin
            slot = 6'($urandom_range(cap - 1));
         end else begin
            slot = 6'($urandom_range(63));
         end
         data = {$urandom, $urandom};
         queue_request(func, pool, slot, data);
      end
   endtask

   initial begin
      sender_idle_pct = 18;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_until_idle();

      // Directed part. Pool 0 is manual, pool 1 a two-deep stack, pool 2 a
      // three-deep queue and pool 3 carries the invalid mode.
      write_all_registers(3'd4, {MODE_INVALID, MODE_QUEUE, MODE_STACK, MODE_MANUAL},
                          7'd64, 7'd2, 7'd3, 7'd5);
      queue_request(FUNC_PUT, 2'd0, 6'd63, '1);
      queue_request(FUNC_GET, 2'd0, 6'd63, '0);
      queue_request(FUNC_GET, 2'd0, 6'd0, '1);
      queue_request(FUNC_UNKNOWN, 2'd0, 6'd0, '1);
      queue_request(FUNC_GET, 2'd1, 6'd0, '0);
      queue_request(FUNC_PUT, 2'd1, 6'd0, {$urandom, $urandom});
      queue_request(FUNC_PUT, 2'd1, 6'd63, {$urandom, $urandom});
      queue_request(FUNC_PUT, 2'd1, 6'd0, {$urandom, $urandom});
      queue_request(FUNC_GET, 2'd1, 6'd0, '0);
      queue_request(FUNC_GET, 2'd2, 6'd0, '0);
      queue_request(FUNC_PUT, 2'd2, 6'd0, {$urandom, $urandom});
      queue_request(FUNC_PUT, 2'd2, 6'd0, {$urandom, $urandom});
      queue_request(FUNC_PUT, 2'd2, 6'd0, {$urandom, $urandom});
      // The queue is full with nothing taken yet, so this put is refused.
      queue_request(FUNC_PUT, 2'd2, 6'd0, {$urandom, $urandom});
      queue_request(FUNC_GET, 2'd2, 6'd0, '0);
      // The slot freed at the bottom lets the next put compact the queue.
      queue_request(FUNC_PUT, 2'd2, 6'd0, {$urandom, $urandom});
      queue_request(FUNC_GET, 2'd2, 6'd0, '0);
      queue_request(FUNC_GET, 2'd2, 6'd0, '0);
      queue_request(FUNC_PUT, 2'd3, 6'd0, '1);
      queue_request(FUNC_FLUSH, 2'd3, 6'd0, '0);
      queue_request(FUNC_FLUSH, 2'd0, 6'd0, '0);
      queue_request(FUNC_GET, 2'd0, 6'd63, '0);
      wait_until_idle();

      // Only two pools exist now, pool 0 shrinks and pool 1 gets an oversized
      // capacity. The stack keeps its old top pointer.
      write_register(CSR_POOLS_CREATED, 8'd2);
      write_register(CSR_CAPACITY0, 8'd10);
      write_register(CSR_CAPACITY1, 8'd127);
      queue_request(FUNC_GET, 2'd0, 6'd10, '0);
      queue_request(FUNC_PUT, 2'd2, 6'd0, '1);
      queue_request(FUNC_PUT, 2'd1, 6'd0, {$urandom, $urandom});
      wait_until_idle();

      // A pool count above the pool total acts as the pool total.
      write_register(CSR_POOLS_CREATED, 8'd7);
      queue_request(FUNC_GET, 2'd3, 6'd0, '0);
      wait_until_idle();

      // Random phases. The sender idles lightly, then heavily, then not at all.
      for (int phase = 0; phase < 17; phase++) begin
         sender_idle_pct = (phase < 6) ? 18 : (phase < 12) ? 45 : 0;
         configure_random_phase(phase);
         plan_random_phase((phase == 7) ? 40 : 100);
         wait_until_idle();
      end

      // Leave room for a stray result beat to show up before the verdict.
      repeat (80) @(posedge clock);
      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
